FILE: rtl/mrr_pkg.sv
`timescale 1ns / 1ps

package mrr_pkg;

    // Generator constants: modulus 2^31-1 and the minimal standard multiplier.
    localparam logic [30:0] MODULUS    = 31'h7FFF_FFFF;
    localparam logic [15:0] MULTIPLIER = 16'd48271;
    localparam logic [30:0] SEED_RESET = 31'd1;

    // Depth of the request queue between front and back.
    localparam int QUEUE_DEPTH = 2;

    // One remainder bit per step, one step per dividend bit.
    localparam int DIV_STEPS = 31;

    typedef struct packed {
        logic signed [31:0] range_from;
        logic signed [31:0] range_to;
    } mrr_req_t;

    typedef struct packed {
        logic        [30:0] raw_value;
        logic signed [31:0] ranged_value;
    } mrr_rsp_t;

    // A request as held in the queue: the lower bound and the exact span.
    typedef struct packed {
        logic signed [31:0] range_from;
        logic signed [32:0] span;
    } mrr_job_t;

endpackage

FILE: rtl/mrr_front.sv
`timescale 1ns / 1ps

module mrr_front (
    input  logic              s_valid,
    output logic              s_ready,
    input  mrr_pkg::mrr_req_t s_data,
    output logic              job_valid,
    input  logic              job_ready,
    output mrr_pkg::mrr_job_t job_data
);

    logic signed [32:0] from_ext;
    logic signed [32:0] to_ext;

    // The span is taken at 33 bits so that it is exact for every pair of bounds.
    assign from_ext = {s_data.range_from[31], s_data.range_from};
    assign to_ext   = {s_data.range_to[31], s_data.range_to};

    assign job_valid           = s_valid;
    assign s_ready             = job_ready;
    assign job_data.range_from = s_data.range_from;
    assign job_data.span       = to_ext - from_ext;

endmodule

FILE: rtl/mrr_queue.sv
`timescale 1ns / 1ps

module mrr_queue #(
    parameter int DEPTH = mrr_pkg::QUEUE_DEPTH
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  mrr_pkg::mrr_job_t in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output mrr_pkg::mrr_job_t out_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    mrr_pkg::mrr_job_t entries_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              push, pop;

    assign in_ready  = (count_reg != CNT_W'(DEPTH));
    assign out_valid = (count_reg != '0);
    assign out_data  = entries_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entries_reg[wr_ptr_reg] <= in_data;
        end
    end

endmodule

FILE: rtl/mrr_back.sv
`timescale 1ns / 1ps

module mrr_back (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              job_valid,
    output logic              job_ready,
    input  mrr_pkg::mrr_job_t job_data,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [30:0]       cfg_data,
    output logic              m_valid,
    input  logic              m_ready,
    output mrr_pkg::mrr_rsp_t m_data
);

    localparam int CNT_W = $clog2(mrr_pkg::DIV_STEPS);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RED,
        ST_DIV,
        ST_FIN
    } state_t;

    state_t             state_reg, state_next;
    logic [30:0]        seed_reg, seed_next;
    logic [30:0]        gen_reg, gen_next;
    logic [46:0]        prod_reg, prod_next;
    logic [32:0]        size_reg, size_next;
    logic signed [31:0] from_reg, from_next;
    logic [30:0]        raw_reg, raw_next;
    logic [30:0]        dvd_reg, dvd_next;
    logic [32:0]        rem_reg, rem_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               out_valid_reg, out_valid_next;
    mrr_pkg::mrr_rsp_t  out_reg, out_next;

    logic [30:0] cur_state;
    logic [31:0] fold_sum;
    logic [31:0] fold_red;
    logic [30:0] new_state;
    logic [33:0] trial;
    logic [33:0] size_ext;

    assign job_ready = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_valid   = out_valid_reg;
    assign m_data    = out_reg;

    // A zero state is refilled from the seed before it is stepped.
    assign cur_state = (gen_reg == '0) ? seed_reg : gen_reg;

    // 2^31 = 1 modulo 2^31-1, so the high part of the product folds onto the low part.
    // A result congruent to zero is given as the modulus itself.
    assign fold_sum  = {1'b0, prod_reg[30:0]} + {16'd0, prod_reg[46:31]};
    assign fold_red  = (fold_sum >= {1'b0, mrr_pkg::MODULUS})
                     ? fold_sum - {1'b0, mrr_pkg::MODULUS} : fold_sum;
    assign new_state = (fold_red == '0) ? mrr_pkg::MODULUS : fold_red[30:0];

    // Restoring remainder step: bring in the next dividend bit, subtract if it fits.
    assign trial    = {rem_reg, dvd_reg[30]};
    assign size_ext = {1'b0, size_reg};

    always_comb begin
        state_next     = state_reg;
        seed_next      = seed_reg;
        gen_next       = gen_reg;
        prod_next      = prod_reg;
        size_next      = size_reg;
        from_next      = from_reg;
        raw_next       = raw_reg;
        dvd_next       = dvd_reg;
        rem_next       = rem_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;

        if (out_valid_reg && m_ready) begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (job_valid) begin
                    from_next  = job_data.range_from;
                    // Size is the absolute span plus one; it never comes out as zero.
                    size_next  = job_data.span[32] ? (~job_data.span) + 33'd2
                                                   : job_data.span + 33'd1;
                    prod_next  = {16'd0, cur_state} * {31'd0, mrr_pkg::MULTIPLIER};
                    state_next = ST_RED;
                end
            end
            ST_RED: begin
                gen_next   = new_state;
                raw_next   = new_state;
                dvd_next   = new_state;
                rem_next   = '0;
                cnt_next   = '0;
                state_next = ST_DIV;
            end
            ST_DIV: begin
                if (trial >= size_ext) begin
                    rem_next = 33'(trial - size_ext);
                end else begin
                    rem_next = trial[32:0];
                end
                dvd_next = {dvd_reg[29:0], 1'b0};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(mrr_pkg::DIV_STEPS - 1)) begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN: begin
                if (!out_valid_reg || m_ready) begin
                    out_next.raw_value    = raw_reg;
                    out_next.ranged_value = from_reg + signed'(rem_reg[31:0]);
                    out_valid_next        = 1'b1;
                    state_next            = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // A seed write reloads the generator at once.
        if (cfg_valid) begin
            seed_next = cfg_data;
            gen_next  = cfg_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            seed_reg      <= mrr_pkg::SEED_RESET;
            gen_reg       <= mrr_pkg::SEED_RESET;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            seed_reg      <= seed_next;
            gen_reg       <= gen_next;
            out_valid_reg <= out_valid_next;
        end
        prod_reg <= prod_next;
        size_reg <= size_next;
        from_reg <= from_next;
        raw_reg  <= raw_next;
        dvd_reg  <= dvd_next;
        rem_reg  <= rem_next;
        cnt_reg  <= cnt_next;
        out_reg  <= out_next;
    end

`ifndef SYNTHESIS
    // The partial remainder always stays below the divisor.
    a_rem_below_size: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIV) |-> (rem_reg < size_reg))
        else $error("partial remainder reached the divisor");

    // A freshly stepped generator value is never zero.
    a_raw_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_RED) |=> (raw_reg != '0))
        else $error("generator stepped to zero");

    // The finished remainder never exceeds the raw value it was taken from.
    a_rem_le_raw: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FIN) |-> (rem_reg <= {2'b00, raw_reg}))
        else $error("remainder exceeds raw value");

    // A word left waiting on the result port is not overwritten.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !m_ready) |=> (out_valid_reg && $stable(out_reg)))
        else $error("pending result word changed");
`endif

endmodule

FILE: rtl/minstd_ranged_random_top.sv
`timescale 1ns / 1ps

// Ranged minimal standard random number generator (multiplier 48271, modulus 2^31-1).
// Input channel s_*: each word carries a lower and an inclusive upper bound.
// Result channel m_*: each word carries the new 31-bit generator value and
// range_from plus that value modulo (|range_to - range_from| + 1), wrapped to 32 bits.
// Configuration channel cfg_*: a write stores the seed and reloads the generator
// at once; it is always ready and should only be used while no request is in flight.
// The back end takes one request at a time: it reads the queue and multiplies,
// folds the product, runs the bit-serial remainder unit one dividend bit per step
// and loads the output register, and only then takes the next request from the
// queue.
// A two-word queue sits between the front end and the back end, so requests are
// accepted while an earlier one is still being worked on.
// When the receiver stalls, the finished word waits in the output register and the
// back end holds its next result until that register is free; the queue then fills
// and s_ready falls.
// Reset (aresetn, synchronous, active low) empties the queue and the output
// register and loads seed and generator with 1.
module minstd_ranged_random_top #(
    parameter int QUEUE_DEPTH = mrr_pkg::QUEUE_DEPTH
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  mrr_pkg::mrr_req_t s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output mrr_pkg::mrr_rsp_t m_data,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [30:0]       cfg_data
);

    logic              push_valid, push_ready;
    mrr_pkg::mrr_job_t push_data;
    logic              pop_valid, pop_ready;
    mrr_pkg::mrr_job_t pop_data;

    // The front end works out the exact span of the bounds as the word arrives.
    mrr_front u_front (
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .job_valid (push_valid),
        .job_ready (push_ready),
        .job_data  (push_data)
    );

    mrr_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (push_valid),
        .in_ready  (push_ready),
        .in_data   (push_data),
        .out_valid (pop_valid),
        .out_ready (pop_ready),
        .out_data  (pop_data)
    );

    // The back end steps the generator and reduces it into the requested range.
    mrr_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .job_valid (pop_valid),
        .job_ready (pop_ready),
        .job_data  (pop_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule

FILE: sim/mrr_lehmer_checker.sv
`timescale 1ns / 1ps

module mrr_lehmer_checker (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    input  logic              s_ready,
    input  mrr_pkg::mrr_req_t s_data,
    input  logic              m_valid,
    input  logic              m_ready,
    input  mrr_pkg::mrr_rsp_t m_data,
    input  logic              cfg_valid,
    input  logic              cfg_ready,
    input  logic [30:0]       cfg_data,
    output int                mismatch_count,
    output int                outstanding
);

    localparam logic [63:0] LEHMER_MOD = 64'd2147483647;
    localparam logic [63:0] LEHMER_MUL = 64'd48271;

    logic [30:0]       seed_reg;
    logic [30:0]       lehmer_state;
    mrr_pkg::mrr_rsp_t expected_words[$];
    int                errors = 0;

    function automatic logic [30:0] lehmer_advance(input logic [30:0] cur);
        logic [63:0] prod;
        prod = (64'(cur) * LEHMER_MUL) % LEHMER_MOD;
        // A product congruent to zero comes out as the modulus itself.
        if (prod == 64'd0) begin
            prod = LEHMER_MOD;
        end
        return prod[30:0];
    endfunction

    function automatic mrr_pkg::mrr_rsp_t predict_word(input mrr_pkg::mrr_req_t req);
        mrr_pkg::mrr_rsp_t word;
        longint            lo;
        longint            hi;
        longint            span;
        logic [63:0]       rem;
        if (lehmer_state == 31'd0) begin
            lehmer_state = seed_reg;
        end
        lehmer_state = lehmer_advance(lehmer_state);
        lo = longint'(req.range_from);
        hi = longint'(req.range_to);
        span = hi - lo;
        if (span < 0) begin
            span = -span;
        end
        span = span + 1;
        rem = 64'(lehmer_state) % 64'(span);
        word.raw_value    = lehmer_state;
        word.ranged_value = req.range_from + rem[31:0];
        return word;
    endfunction

    always @(posedge aclk) begin : track
        mrr_pkg::mrr_rsp_t want;
        if (!aresetn) begin
            seed_reg     = 31'd1;
            lehmer_state = 31'd1;
            expected_words.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                seed_reg     = cfg_data;
                lehmer_state = cfg_data;
            end
            // Results are retired before new requests are queued, so that a word
            // arriving with nothing outstanding is always caught.
            if (m_valid && m_ready) begin
                if (expected_words.size() == 0) begin
                    $error("result word with no request outstanding: %s %0d %s %0d",
                           "raw_value", m_data.raw_value,
                           "ranged_value", m_data.ranged_value);
                    errors++;
                end else begin
                    want = expected_words.pop_front();
                    if (m_data.raw_value !== want.raw_value) begin
                        $error("raw_value mismatch: expected %0d, actual %0d",
                               want.raw_value, m_data.raw_value);
                        errors++;
                    end
                    if (m_data.ranged_value !== want.ranged_value) begin
                        $error("ranged_value mismatch: expected %0d, actual %0d",
                               want.ranged_value, m_data.ranged_value);
                        errors++;
                    end
                end
            end
            if (s_valid && s_ready) begin
                expected_words.push_back(predict_word(s_data));
            end
        end
        mismatch_count <= errors;
        outstanding    <= expected_words.size();
    end

endmodule

FILE: sim/minstd_ranged_random_top_tb.sv
`timescale 1ns / 1ps

module minstd_ranged_random_top_tb;

    // Random part: four phases of this many words each.
    localparam int PHASE_WORDS   = 200;
    // Cycles allowed after the last result for any stray word to show up.
    localparam int SETTLE_CYCLES = 40;
    // Limit for the whole run, well above what the slowest correct run needs.
    localparam int LIMIT_CYCLES  = 500000;
    localparam int IDLE_PERCENT  = 13;

    localparam logic [30:0] SEED_ZERO     = 31'd0;
    localparam logic [30:0] SEED_MIN      = 31'd1;
    localparam logic [30:0] SEED_TOP      = 31'h7FFF_FFFE;
    localparam logic [30:0] SEED_MODULUS  = 31'h7FFF_FFFF;

    localparam logic [31:0] INT_MIN = 32'h8000_0000;
    localparam logic [31:0] INT_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] ALL_ONE = 32'hFFFF_FFFF;

    logic              aclk = 1'b0;
    logic              aresetn;
    logic              s_valid;
    logic              s_ready;
    mrr_pkg::mrr_req_t s_data;
    logic              m_valid;
    logic              m_ready = 1'b0;
    mrr_pkg::mrr_rsp_t m_data;
    logic              cfg_valid;
    logic              cfg_ready;
    logic [30:0]       cfg_data;

    int   mismatch_count;
    int   outstanding;
    int   cycle_count = 0;
    // When set, neither the sender nor the receiver idles.
    logic quiet;

    minstd_ranged_random_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // The checker follows every handshake on its own, keeps the expected words
    // and reports how many mismatches it has seen and how many words are due.
    mrr_lehmer_checker u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_data         (s_data),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_data         (m_data),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data),
        .mismatch_count (mismatch_count),
        .outstanding    (outstanding)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // The receiver stalls at random, except during the quiet stretch.
    always @(posedge aclk) begin
        m_ready <= quiet || ($urandom_range(0, 99) >= IDLE_PERCENT);
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("minstd_ranged_random_top_tb failed");
            $finish;
        end
    end

    // Presents one request word and returns at the edge where it is taken. A
    // random gap with valid low may come first; otherwise valid simply stays high
    // and the payload changes, so valid is never dropped and raised in one step.
    task automatic send_range(input logic [31:0] lo, input logic [31:0] hi);
        if (!quiet) begin
            while ($urandom_range(0, 99) < IDLE_PERCENT) begin
                s_valid <= 1'b0;
                @(posedge aclk);
            end
        end
        s_valid <= 1'b1;
        s_data  <= '{range_from: lo, range_to: hi};
        do @(posedge aclk); while (!s_ready);
    endtask

    // Holds the sender back until every outstanding word has been received. The
    // first edge is waited for so that the checker has counted the last request.
    task automatic drain_results;
        s_valid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) begin
            @(posedge aclk);
        end
    endtask

    // The seed is only written with the block idle, as it reloads the generator.
    task automatic write_seed(input logic [30:0] seed);
        drain_results();
        cfg_valid <= 1'b1;
        cfg_data  <= seed;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // Bounds drawn in several shapes: wholly random pairs give wide ranges, near
    // pairs give narrow ones in both orders, and the extremes force wrap-around.
    task automatic pick_bounds(output logic [31:0] lo, output logic [31:0] hi);
        logic [31:0] edges[4];
        edges = '{INT_MIN, INT_MAX, 32'h0, ALL_ONE};
        lo = $urandom;
        case ($urandom_range(0, 9))
            0, 1, 2: begin
                hi = $urandom;
            end
            3, 4: begin
                hi = lo + $urandom_range(0, 1000);
            end
            5: begin
                hi = lo - $urandom_range(0, 1000);
            end
            6: begin
                hi = lo;
            end
            7: begin
                lo = edges[$urandom_range(0, 3)];
                hi = $urandom;
            end
            8: begin
                hi = lo + ($urandom >> $urandom_range(0, 31));
            end
            default: begin
                hi = edges[$urandom_range(0, 3)];
            end
        endcase
    endtask

    initial begin : stimulus
        logic [31:0] lo;
        logic [31:0] hi;
        aresetn     = 1'b0;
        s_valid     = 1'b0;
        s_data      = '0;
        cfg_valid   = 1'b0;
        cfg_data    = '0;
        quiet       = 1'b0;

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed words with the reset seed of one.
        send_range(32'h0, 32'h0);
        // Full range, a size of two to the power 32, in both orders.
        send_range(INT_MIN, INT_MAX);
        send_range(INT_MAX, INT_MIN);
        // Reversed bounds count upwards from the lower field.
        send_range(32'd5, 32'd1);
        send_range(32'd1, 32'd5);
        send_range(-32'sd10, -32'sd3);
        send_range(INT_MAX, INT_MAX);
        send_range(INT_MIN, INT_MIN);
        send_range(32'h0, ALL_ONE);
        // Ranges at and near the largest positive value; from INT_MAX the result can wrap past it.
        send_range(32'h7FFF_FFF0, INT_MAX);
        send_range(INT_MAX, 32'h0);
        send_range(ALL_ONE, INT_MAX);

        // A zero seed: the zero state reloads zero, and the generator then sticks
        // at the modulus.
        write_seed(SEED_ZERO);
        send_range(32'h0, 32'd9);
        send_range(INT_MIN, INT_MAX);
        send_range(32'd3, 32'd3);

        // A seed equal to the modulus locks the generator the same way.
        write_seed(SEED_MODULUS);
        send_range(32'd10, 32'd0);
        send_range(ALL_ONE, INT_MIN);
        send_range(INT_MAX, ALL_ONE);

        // The largest ordinary seed.
        write_seed(SEED_TOP);
        send_range(32'h0, INT_MAX);
        send_range(INT_MIN, 32'h0);
        send_range(32'd7, 32'd100);

        // Random phases, each starting from a fresh seed. The third phase runs
        // without any idling on either side.
        for (int phase = 0; phase < 4; phase++) begin
            if (phase == 0) begin
                write_seed(SEED_MIN);
            end else begin
                write_seed(31'($urandom_range(1, 32'h7FFF_FFFE)));
            end
            quiet <= (phase == 2);
            for (int n = 0; n < PHASE_WORDS; n++) begin
                // Half way through the second phase the sender waits for the
                // pipeline to empty completely before carrying on.
                if (phase == 1 && n == PHASE_WORDS / 2) begin
                    drain_results();
                end
                pick_bounds(lo, hi);
                send_range(lo, hi);
            end
        end

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("minstd_ranged_random_top_tb passed");
        end else begin
            $display("minstd_ranged_random_top_tb failed");
        end
        $finish;
    end

endmodule
